FILE: hdl/wire_distance_energy_gradient_unit_assert.svh
// Assertion macros shared by the wire distance unit.
`ifndef WIRE_DISTANCE_ENERGY_GRADIENT_UNIT_ASSERT_SVH
`define WIRE_DISTANCE_ENERGY_GRADIENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WDEG_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WDEG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/wdeg_pkg.sv
// Shared types and constants of the wire distance unit.
`default_nettype none
package wdeg_pkg;

	// Distance metric selected by the mode register; the unused code acts as Euclidean.
	typedef enum logic [1:0] {
		DM_MANHATTAN = 2'd0,
		DM_SQUARED   = 2'd1,
		DM_EUCLID    = 2'd2
	} dist_mode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_X_SCALE  = 2'd1;
	localparam logic [1:0] REG_Y_SCALE  = 2'd2;
	localparam logic [1:0] REG_GRAD_EN  = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SCALE_W    = 16;
	localparam int COST_W     = 32;
	localparam int OUT_W      = 64;

	// Width of the operand slice that one multiplier stage consumes.
	localparam int MUL_CHUNK  = 16;

endpackage
`default_nettype wire

FILE: hdl/wdeg_dly.sv
// Stallable delay line that keeps side data aligned with the deep pipeline.
`default_nettype none
module wdeg_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] dly_s [N];

	// Shift the taps forward whenever the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	assign q = dly_s[N-1];

endmodule
`default_nettype wire

FILE: hdl/wdeg_mul.sv
// Pipelined unsigned multiplier that adds one 16-bit slice of b per stage.
`default_nettype none
module wdeg_mul #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic      [A_W+B_W-1:0] p
);

	localparam int CH  = wdeg_pkg::MUL_CHUNK;
	localparam int NC  = (B_W + CH - 1) / CH;
	localparam int BP  = NC * CH;
	localparam int P_W = A_W + B_W;

	logic [BP-1:0]  b_pad;
	logic [P_W-1:0] acc_s [NC];
	logic [A_W-1:0] a_s   [NC-1];
	logic [BP-1:0]  b_s   [NC-1];

	assign b_pad = BP'(b);

	// One partial product per stage, accumulated at its slice weight.
	for (genvar k = 0; k < NC; k++) begin : g_stage
		logic [A_W+CH-1:0] pp;
		if (k == 0) begin : g_first
			assign pp = (A_W+CH)'(a) * (A_W+CH)'(b_pad[0 +: CH]);
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[0] <= P_W'(pp);
				end
			end
		end else begin : g_next
			assign pp = (A_W+CH)'(a_s[k-1]) * (A_W+CH)'(b_s[k-1][k*CH +: CH]);
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k] <= acc_s[k-1] + (P_W'(pp) << (k * CH));
				end
			end
		end
		if (k < NC - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k] <= (k == 0) ? a : a_s[k == 0 ? 0 : k-1];
					b_s[k] <= (k == 0) ? b_pad : b_s[k == 0 ? 0 : k-1];
				end
			end
		end
	end

	assign p = acc_s[NC-1];

endmodule
`default_nettype wire

FILE: hdl/wdeg_sqrt.sv
// Pipelined integer square root, one root bit per stage, result rounded down.
`default_nettype none
module wdeg_sqrt #(
	parameter int Q_W = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [Q_W-1:0]   num,
	output logic      [Q_W/2-1:0] root
);

	localparam int R_W = Q_W / 2;

	logic [R_W-1:0] root_s [R_W];
	logic [R_W:0]   rem_s  [R_W];
	logic [Q_W-1:0] num_s  [R_W-1];

	// Each stage brings down two radicand bits and tries the next root bit.
	for (genvar i = 0; i < R_W; i++) begin : g_stage
		logic [Q_W-1:0] num_in;
		logic [R_W:0]   rem_in;
		logic [R_W-1:0] root_in;
		logic [R_W+1:0] t;
		logic [R_W+1:0] trial;
		logic           ge;
		if (i == 0) begin : g_first
			assign num_in  = num;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign num_in  = num_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end
		assign t     = (R_W+2)'({rem_in, num_in[Q_W-1 -: 2]});
		assign trial = {root_in, 2'b01};
		assign ge    = (t >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= (R_W+1)'(ge ? t - trial : t);
				root_s[i] <= {root_in[R_W-2:0], ge};
			end
		end
		if (i < R_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[i] <= num_in << 2;
				end
			end
		end
	end

	assign root = root_s[R_W-1];

endmodule
`default_nettype wire

FILE: hdl/wdeg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module wdeg_div #(
	parameter int N_W = 16,
	parameter int D_W = 8
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [N_W-1:0] num,
	input  wire logic [D_W-1:0] den,
	output logic      [N_W-1:0] quo
);

	// Dividend bits leave at the top while quotient bits enter at the bottom.
	logic [N_W-1:0] qn_s  [N_W];
	logic [D_W-1:0] rem_s [N_W];
	logic [D_W-1:0] den_s [N_W-1];

	for (genvar i = 0; i < N_W; i++) begin : g_stage
		logic [N_W-1:0] qn_in;
		logic [D_W-1:0] rem_in;
		logic [D_W-1:0] den_in;
		logic [D_W:0]   t;
		logic           ge;
		if (i == 0) begin : g_first
			assign qn_in  = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign qn_in  = qn_s[i-1];
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
		end
		assign t  = {rem_in, qn_in[N_W-1]};
		assign ge = (t >= {1'b0, den_in});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= D_W'(ge ? t - {1'b0, den_in} : t);
				qn_s[i]  <= {qn_in[N_W-2:0], ge};
			end
		end
		if (i < N_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quo = qn_s[N_W-1];

endmodule
`default_nettype wire

FILE: hdl/wire_distance_energy_gradient_unit.sv
// Wire distance cost and gradient unit: top level with the full item pipeline.
//
// Takes one wire item per clock while the output is not stalled and returns one
// result item per wire, in order. The Euclidean path's square root yields one
// root bit per stage and its gradient divider yields one quotient bit per stage.
// A stalled output holds the whole pipeline; bubbles drain toward the output.
// The user must write configuration only while no item is in flight; the block
// itself does not enforce this.
`default_nettype none
`include "wire_distance_energy_gradient_unit_assert.svh"
module wire_distance_energy_gradient_unit #(
	parameter int COORD_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// Input items.
	input  wire logic s_tvalid,
	output logic      s_tready,
	// Fields from bit 0: block0_x, block0_y, port0_xsum, port0_ysum,
	// block1_x, block1_y, port1_xsum, port1_ysum, cost, zero fill.
	input  wire logic [((8*COORD_BITS+36+7)/8)*8-1:0] s_tdata,
	// Fields from bit 0: has_blocks.
	input  wire logic [0:0] s_tuser,
	// Result items.
	output logic        m_tvalid,
	input  wire logic   m_tready,
	// Fields from bit 0: energy, grad_x, grad_y.
	output logic [191:0] m_tdata,
	// Configuration writes.
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [wdeg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wdeg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int CW  = wdeg_pkg::COST_W;
	localparam int OW  = wdeg_pkg::OUT_W;
	localparam int CH  = wdeg_pkg::MUL_CHUNK;
	localparam int DW  = CB + 3;
	localparam int UW  = CB + 2;
	localparam int AW  = UW + wdeg_pkg::SCALE_W;
	localparam int SW  = 2 * AW + 1;
	localparam int QW  = ((SW + 14 + 1) / 2) * 2;
	localparam int LW  = QW / 2;
	localparam int NW  = CW + AW + 7;
	localparam int XW  = CW + SW;
	localparam int NCA = (AW + CH - 1) / CH;
	localparam int NCM = (AW + 1 + CH - 1) / CH;
	localparam int NCS = (SW + CH - 1) / CH;
	localparam int NCL = (LW + CH - 1) / CH;
	localparam int T_S = 4 + NCA;
	localparam int T_L = T_S + LW;
	localparam int T_Q = T_L + NW;
	localparam int T_END = T_Q + 1;

	// Saturate an unsigned magnitude to 64 bits.
	function automatic logic [OW-1:0] usat(input logic [XW-1:0] x);
		logic over;
		over = |x[XW-1:OW];
		return over ? {OW{1'b1}} : x[OW-1:0];
	endfunction

	// Apply a sign to a magnitude and saturate to the signed 64-bit range.
	function automatic logic [OW-1:0] ssat(input logic [XW-1:0] mag, input logic neg);
		logic [OW-1:0] r;
		if (!neg) begin
			r = (|mag[XW-1:OW-1]) ? {1'b0, {(OW-1){1'b1}}} : mag[OW-1:0];
		end else if (|mag[XW-1:OW] || (mag[OW-1] && |mag[OW-2:0])) begin
			r = {1'b1, {(OW-1){1'b0}}};
		end else begin
			r = -mag[OW-1:0];
		end
		return r;
	endfunction

	// Configuration registers; the port always takes a write.
	wdeg_pkg::dist_mode_t mode_q;
	logic [wdeg_pkg::SCALE_W-1:0] xscale_q;
	logic [wdeg_pkg::SCALE_W-1:0] yscale_q;
	logic gen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= wdeg_pkg::DM_MANHATTAN;
			xscale_q <= 16'd256;
			yscale_q <= 16'd256;
			gen_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wdeg_pkg::REG_MODE:    mode_q <= wdeg_pkg::dist_mode_t'(cfg_data[1:0]);
				wdeg_pkg::REG_X_SCALE: xscale_q <= cfg_data;
				wdeg_pkg::REG_Y_SCALE: yscale_q <= cfg_data;
				wdeg_pkg::REG_GRAD_EN: gen_q <= cfg_data[0];
				default:               gen_q <= gen_q;
			endcase
		end
	end

	// Global advance: the pipeline moves unless a finished item is held.
	logic             en;
	logic [T_END-1:0] vld_q;

	assign m_tvalid = vld_q[T_END-1];
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T_END-2:0], s_tvalid};
		end
	end

	// Unpack the input item.
	logic signed [CB-1:0] b0x, b0y, b1x, b1y;
	logic signed [CB:0]   p0x, p0y, p1x, p1y;
	logic [CW-1:0]        cost_in;

	assign b0x     = s_tdata[0 +: CB];
	assign b0y     = s_tdata[CB +: CB];
	assign p0x     = s_tdata[2*CB +: CB+1];
	assign p0y     = s_tdata[3*CB+1 +: CB+1];
	assign b1x     = s_tdata[4*CB+2 +: CB];
	assign b1y     = s_tdata[5*CB+2 +: CB];
	assign p1x     = s_tdata[6*CB+2 +: CB+1];
	assign p1y     = s_tdata[7*CB+3 +: CB+1];
	assign cost_in = s_tdata[8*CB+4 +: CW];

	// Stage 1: doubled center offsets.
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [CW-1:0]        c_s1;
	logic                 grad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (DW'(p1x) - DW'(p0x)) +
				(s_tuser[0] ? ((DW'(b1x) - DW'(b0x)) <<< 1) : DW'(0));
			dy_s1 <= (DW'(p1y) - DW'(p0y)) +
				(s_tuser[0] ? ((DW'(b1y) - DW'(b0y)) <<< 1) : DW'(0));
			c_s1    <= cost_in;
			grad_s1 <= s_tuser[0] && gen_q;
		end
	end

	// Stage 2: magnitudes and signs.
	logic [UW-1:0] ux_s2, uy_s2;
	logic          nx_s2, ny_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s2 <= UW'(dx_s1[DW-1] ? -dx_s1 : dx_s1);
			uy_s2 <= UW'(dy_s1[DW-1] ? -dy_s1 : dy_s1);
			nx_s2 <= dx_s1[DW-1];
			ny_s2 <= dy_s1[DW-1];
		end
	end

	// Stage 3: scaled offsets.
	logic [AW-1:0] ax_s3, ay_s3;
	logic          nx_s3, ny_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3 <= AW'(ux_s2) * AW'(xscale_q);
			ay_s3 <= AW'(uy_s2) * AW'(yscale_q);
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
		end
	end

	// Stage 4: Manhattan length; a negative offset that scales to zero counts as positive.
	logic [AW:0] msum_s4;
	logic        nx_s4, ny_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			msum_s4 <= (AW+1)'(ax_s3) + (AW+1)'(ay_s3);
			nx_s4   <= nx_s3 && (ax_s3 != '0);
			ny_s4   <= ny_s3 && (ay_s3 != '0);
		end
	end

	// Cost copies aligned to each multiplier that uses it and to the final stage.
	logic [CW-1:0] c_a3, c_a4, c_as, c_al, c_aq;

	wdeg_dly #(.W(CW), .N(2))       u_c3 (.clk, .en, .d(c_s1), .q(c_a3));
	wdeg_dly #(.W(CW), .N(3))       u_c4 (.clk, .en, .d(c_s1), .q(c_a4));
	wdeg_dly #(.W(CW), .N(T_S-1))   u_cs (.clk, .en, .d(c_s1), .q(c_as));
	wdeg_dly #(.W(CW), .N(T_L-1))   u_cl (.clk, .en, .d(c_s1), .q(c_al));
	wdeg_dly #(.W(CW), .N(T_Q-1))   u_cq (.clk, .en, .d(c_s1), .q(c_aq));

	// Squares of the scaled offsets and the cost-weighted offsets.
	logic [2*AW-1:0]  axx, ayy;
	logic [CW+AW-1:0] cax, cay;

	wdeg_mul #(.A_W(AW), .B_W(AW)) u_mxx (.clk, .en, .a(ax_s3), .b(ax_s3), .p(axx));
	wdeg_mul #(.A_W(AW), .B_W(AW)) u_myy (.clk, .en, .a(ay_s3), .b(ay_s3), .p(ayy));
	wdeg_mul #(.A_W(CW), .B_W(AW)) u_mcx (.clk, .en, .a(c_a3), .b(ax_s3), .p(cax));
	wdeg_mul #(.A_W(CW), .B_W(AW)) u_mcy (.clk, .en, .a(c_a3), .b(ay_s3), .p(cay));

	// Manhattan energy product.
	logic [CW+AW:0] pm;

	wdeg_mul #(.A_W(CW), .B_W(AW+1)) u_mm (.clk, .en, .a(c_a4), .b(msum_s4), .p(pm));

	// Sum of squares.
	logic [SW-1:0] ssum_s;

	always_ff @(posedge clk) begin
		if (en) begin
			ssum_s <= SW'(axx) + SW'(ayy);
		end
	end

	// Squared energy product.
	logic [CW+SW-1:0] ps;

	wdeg_mul #(.A_W(CW), .B_W(SW)) u_ms (.clk, .en, .a(c_as), .b(ssum_s), .p(ps));

	// Euclidean length in 16 fraction bits.
	logic [LW-1:0] len;

	wdeg_sqrt #(.Q_W(QW)) u_sqrt (.clk, .en, .num(QW'({ssum_s, 14'd0})), .root(len));

	// Euclidean energy product.
	logic [CW+LW-1:0] pl;

	wdeg_mul #(.A_W(CW), .B_W(LW)) u_ml (.clk, .en, .a(c_al), .b(len), .p(pl));

	// Euclidean gradients: cost times offset, scaled, over the length.
	logic [CW+AW-1:0] cax_l, cay_l;
	logic [NW-1:0]    qx, qy;

	wdeg_dly #(.W(CW+AW), .N(T_L-3-NCA)) u_dxl (.clk, .en, .d(cax), .q(cax_l));
	wdeg_dly #(.W(CW+AW), .N(T_L-3-NCA)) u_dyl (.clk, .en, .d(cay), .q(cay_l));

	wdeg_div #(.N_W(NW), .D_W(LW)) u_divx (.clk, .en, .num({cax_l, 7'd0}), .den(len), .quo(qx));
	wdeg_div #(.N_W(NW), .D_W(LW)) u_divy (.clk, .en, .num({cay_l, 7'd0}), .den(len), .quo(qy));

	// Remaining results and flags aligned to the final stage.
	logic [CW+AW:0]   pm_q;
	logic [CW+SW-1:0] ps_q;
	logic [CW+LW-1:0] pl_q;
	logic [CW+AW-1:0] cax_q, cay_q;
	logic             grad_q, nx_q, ny_q, lnz_q;

	wdeg_dly #(.W(CW+AW+1), .N(T_Q-4-NCM))  u_dpm (.clk, .en, .d(pm), .q(pm_q));
	wdeg_dly #(.W(CW+SW), .N(T_Q-T_S-NCS))  u_dps (.clk, .en, .d(ps), .q(ps_q));
	wdeg_dly #(.W(CW+LW), .N(T_Q-T_L-NCL))  u_dpl (.clk, .en, .d(pl), .q(pl_q));
	wdeg_dly #(.W(CW+AW), .N(T_Q-3-NCA))    u_dxq (.clk, .en, .d(cax), .q(cax_q));
	wdeg_dly #(.W(CW+AW), .N(T_Q-3-NCA))    u_dyq (.clk, .en, .d(cay), .q(cay_q));
	wdeg_dly #(.W(1), .N(T_Q-1))            u_dgr (.clk, .en, .d(grad_s1), .q(grad_q));
	wdeg_dly #(.W(1), .N(T_Q-4))            u_dnx (.clk, .en, .d(nx_s4), .q(nx_q));
	wdeg_dly #(.W(1), .N(T_Q-4))            u_dny (.clk, .en, .d(ny_s4), .q(ny_q));
	wdeg_dly #(.W(1), .N(NW))               u_dlz (.clk, .en, .d(len != '0), .q(lnz_q));

	// Final stage: pick the mode's results and saturate.
	logic [OW-1:0] energy_s, gx_s, gy_s;
	logic [OW-1:0] c_ext;

	assign c_ext = OW'(c_aq);

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (mode_q)
				wdeg_pkg::DM_MANHATTAN: begin
					energy_s <= usat(XW'(pm_q) >> 9);
					gx_s <= grad_q ? (nx_q ? -c_ext : c_ext) : '0;
					gy_s <= grad_q ? (ny_q ? -c_ext : c_ext) : '0;
				end
				wdeg_pkg::DM_SQUARED: begin
					energy_s <= usat(XW'(ps_q) >> 18);
					gx_s <= grad_q ? ssat(XW'(cax_q) >> 8, nx_q) : '0;
					gy_s <= grad_q ? ssat(XW'(cay_q) >> 8, ny_q) : '0;
				end
				default: begin
					energy_s <= usat(XW'(pl_q) >> 16);
					gx_s <= (grad_q && lnz_q) ? ssat(XW'(qx), nx_q) : '0;
					gy_s <= (grad_q && lnz_q) ? ssat(XW'(qy), ny_q) : '0;
				end
			endcase
		end
	end

	assign m_tdata = {gy_s, gx_s, energy_s};

	// Checks on the stall and fill logic.
	`WDEG_ASSERT_IMPL(a_held_result_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while a result is held")
	`WDEG_ASSERT_IMPL(a_empty_output_takes_input, !m_tvalid, s_tready, "input refused with an empty output")
	`WDEG_ASSERT_NEXT(a_accepted_item_enters, s_tvalid && s_tready, vld_q[0], "accepted item did not enter the pipeline")

endmodule
`default_nettype wire
